// File: rtl/point_box_query_unit_macros.svh
// Assertion macros shared by the point-to-box query RTL
`ifndef POINT_BOX_QUERY_UNIT_MACROS_SVH
`define POINT_BOX_QUERY_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// whenever ante holds, cons holds in the same cycle
`define PBQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// cond never holds
`define PBQ_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`else

`define PBQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define PBQ_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// File: rtl/pbq_pkg.sv
// Shared widths, register codes and pipeline types for the point-to-box query unit
`timescale 1ns / 1ps
`default_nettype none

package pbq_pkg;

	// coordinate width, signed Q12.4 at the default
	localparam int COORD_BITS   = 16;
	localparam int HALF_BITS    = COORD_BITS - 1;
	localparam int OUT_BITS     = COORD_BITS + 1;
	localparam int DIFF_BITS    = COORD_BITS + 1;
	localparam int SQ_BITS      = 2 * COORD_BITS;
	localparam int SUM_BITS     = SQ_BITS + 1;

	// root operand: capped at 64 bits (saturating), padded to an even width
	localparam int RT_CAP       = 64;
	localparam int RT_RAW       = (SUM_BITS < RT_CAP) ? SUM_BITS : RT_CAP;
	localparam int RT_BITS      = RT_RAW + (RT_RAW % 2);
	localparam int ROOT_BITS    = RT_BITS / 2;
	localparam int REM_BITS     = ROOT_BITS + 2;

	// pipeline depth: front stages, one stage per root bit, output register
	localparam int FRONT_STAGES = 4;
	localparam int LATENCY      = FRONT_STAGES + ROOT_BITS + 1;

	localparam int CFG_IDX_BITS = 2;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_CENTER_X    = 2'd0,
		REG_CENTER_Y    = 2'd1,
		REG_HALF_WIDTH  = 2'd2,
		REG_HALF_HEIGHT = 2'd3
	} cfg_reg_t;

	// box held in configuration
	typedef struct packed {
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
		logic [HALF_BITS-1:0]         hw;
		logic [HALF_BITS-1:0]         hh;
	} box_cfg_t;

	// results that ride alongside the square root
	typedef struct packed {
		logic signed [OUT_BITS-1:0] near_x;
		logic signed [OUT_BITS-1:0] near_y;
		logic                       in_box;
		logic                       use_root;
		logic [COORD_BITS-1:0]      single_gap;
	} side_t;

endpackage

`default_nettype wire

// File: rtl/point_box_query_unit.sv
// Pipeline: 4 front stages, 17 root stages and an output register between start and done.
// Throughput: one point per cycle; busy is held low, the pipeline never stalls.
// The square-root pipeline, one result bit per stage, sets the depth.
// Results appear for one cycle with done and cannot be held off by the receiver.
// Reset clears the box registers to zero and empties the pipeline.
`timescale 1ns / 1ps
`default_nettype none

`include "point_box_query_unit_macros.svh"

module point_box_query_unit (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   start,
	output logic                                        busy,
	input  wire logic signed [pbq_pkg::COORD_BITS-1:0]  point_x,
	input  wire logic signed [pbq_pkg::COORD_BITS-1:0]  point_y,
	input  wire logic                                   cfg_we,
	input  wire logic [pbq_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  wire logic [pbq_pkg::COORD_BITS-1:0]         cfg_wdata,
	output logic                                        done,
	output logic signed [pbq_pkg::OUT_BITS-1:0]         near_x,
	output logic signed [pbq_pkg::OUT_BITS-1:0]         near_y,
	output logic [pbq_pkg::OUT_BITS-1:0]                gap_distance,
	output logic                                        inside_res
);

	localparam int OB = pbq_pkg::OUT_BITS;

	// box registers
	pbq_pkg::box_cfg_t box_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q <= '0;
		end else if (cfg_we) begin
			unique case (pbq_pkg::cfg_reg_t'(cfg_index))
				pbq_pkg::REG_CENTER_X:    box_q.cx <= signed'(cfg_wdata);
				pbq_pkg::REG_CENTER_Y:    box_q.cy <= signed'(cfg_wdata);
				pbq_pkg::REG_HALF_WIDTH:  box_q.hw <= cfg_wdata[pbq_pkg::HALF_BITS-1:0];
				pbq_pkg::REG_HALF_HEIGHT: box_q.hh <= cfg_wdata[pbq_pkg::HALF_BITS-1:0];
				default: ;
			endcase
		end
	end

	// a transaction enters every cycle that start is high
	logic take;

	assign busy = 1'b0;
	assign take = start && !busy;

	// front stages
	logic                          fr_valid;
	logic [pbq_pkg::RT_BITS-1:0]   fr_rad;
	pbq_pkg::side_t                fr_side;

	pbq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (take),
		.point_x   (point_x),
		.point_y   (point_y),
		.box       (box_q),
		.out_valid (fr_valid),
		.rad       (fr_rad),
		.side      (fr_side)
	);

	// square root
	logic                          rt_valid;
	logic [pbq_pkg::ROOT_BITS-1:0] rt_root;
	pbq_pkg::side_t                rt_side;

	pbq_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.rad       (fr_rad),
		.in_side   (fr_side),
		.out_valid (rt_valid),
		.root      (rt_root),
		.out_side  (rt_side)
	);

	// output register: pick the root or the single-axis gap
	logic                       done_q;
	logic signed [OB-1:0]       near_x_q, near_y_q;
	logic [OB-1:0]              gap_q;
	logic                       inside_q;
	logic [OB-1:0]              gap_sel;

	assign gap_sel = rt_side.use_root ? OB'(rt_root) : OB'(rt_side.single_gap);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= rt_valid;
		end
	end

	always_ff @(posedge clk) begin
		near_x_q <= rt_side.near_x;
		near_y_q <= rt_side.near_y;
		gap_q    <= gap_sel;
		inside_q <= rt_side.in_box;
	end

	assign done         = done_q;
	assign near_x       = near_x_q;
	assign near_y       = near_y_q;
	assign gap_distance = gap_q;
	assign inside_res   = inside_q;

	// every result traces back to a transaction a fixed latency earlier
	`PBQ_ASSERT_IMPLY(a_done_latency, clk, arst_n, done, $past(start && !busy, pbq_pkg::LATENCY), "result without a matching transaction")
	// zero distance exactly when the point is in or on the box
	`PBQ_ASSERT_IMPLY(a_inside_gap, clk, arst_n, done, inside_res == (gap_distance == '0), "inside flag disagrees with distance")

endmodule

`default_nettype wire

// File: rtl/pbq_front.sv
// Front pipeline: axis gaps, clamped point, inside flag, squared gaps and their sum
`timescale 1ns / 1ps
`default_nettype none

module pbq_front (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	input  wire logic signed [pbq_pkg::COORD_BITS-1:0] point_x,
	input  wire logic signed [pbq_pkg::COORD_BITS-1:0] point_y,
	input  wire pbq_pkg::box_cfg_t                    box,
	output logic                                      out_valid,
	output logic [pbq_pkg::RT_BITS-1:0]               rad,
	output pbq_pkg::side_t                            side
);

	localparam int C  = pbq_pkg::COORD_BITS;
	localparam int DW = pbq_pkg::DIFF_BITS;

	// stage 1: differences and box limits
	logic signed [DW-1:0] px_e, py_e, cx_e, cy_e, hw_e, hh_e;
	logic                 valid_s1;
	logic signed [DW-1:0] px_s1, py_s1, dx_s1, dy_s1, ndx_s1, ndy_s1;
	logic signed [DW-1:0] lo_x_s1, hi_x_s1, lo_y_s1, hi_y_s1;
	logic [pbq_pkg::HALF_BITS-1:0] hw_s1, hh_s1;

	assign px_e = DW'(point_x);
	assign py_e = DW'(point_y);
	assign cx_e = DW'(box.cx);
	assign cy_e = DW'(box.cy);
	assign hw_e = signed'({2'b00, box.hw});
	assign hh_e = signed'({2'b00, box.hh});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		px_s1   <= px_e;
		py_s1   <= py_e;
		dx_s1   <= cx_e - px_e;
		dy_s1   <= cy_e - py_e;
		ndx_s1  <= px_e - cx_e;
		ndy_s1  <= py_e - cy_e;
		lo_x_s1 <= cx_e - hw_e;
		hi_x_s1 <= cx_e + hw_e;
		lo_y_s1 <= cy_e - hh_e;
		hi_y_s1 <= cy_e + hh_e;
		hw_s1   <= box.hw;
		hh_s1   <= box.hh;
	end

	// stage 2: absolute distance less half extent, clamp onto the box
	logic [C-1:0]         ax, ay;
	logic signed [DW-1:0] near_x_c, near_y_c;
	logic                 valid_s2;
	logic signed [DW-1:0] gx_s2, gy_s2, near_x_s2, near_y_s2;

	assign ax = dx_s1[DW-1] ? ndx_s1[C-1:0] : dx_s1[C-1:0];
	assign ay = dy_s1[DW-1] ? ndy_s1[C-1:0] : dy_s1[C-1:0];

	always_comb begin
		priority if (px_s1 < lo_x_s1) begin
			near_x_c = lo_x_s1;
		end else if (px_s1 > hi_x_s1) begin
			near_x_c = hi_x_s1;
		end else begin
			near_x_c = px_s1;
		end
		priority if (py_s1 < lo_y_s1) begin
			near_y_c = lo_y_s1;
		end else if (py_s1 > hi_y_s1) begin
			near_y_c = hi_y_s1;
		end else begin
			near_y_c = py_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		gx_s2     <= signed'({1'b0, ax}) - signed'({2'b00, hw_s1});
		gy_s2     <= signed'({1'b0, ay}) - signed'({2'b00, hh_s1});
		near_x_s2 <= near_x_c;
		near_y_s2 <= near_y_c;
	end

	// stage 3: square the positive gaps, pick the single-axis distance
	logic                       pos_x, pos_y;
	logic [C-1:0]               gpx, gpy;
	pbq_pkg::side_t             side_c;
	logic                       valid_s3;
	logic [pbq_pkg::SQ_BITS-1:0] sqx_s3, sqy_s3;
	pbq_pkg::side_t             side_s3;

	assign pos_x = !gx_s2[DW-1] && (gx_s2 != '0);
	assign pos_y = !gy_s2[DW-1] && (gy_s2 != '0);
	assign gpx   = pos_x ? gx_s2[C-1:0] : '0;
	assign gpy   = pos_y ? gy_s2[C-1:0] : '0;

	always_comb begin
		side_c.near_x     = near_x_s2;
		side_c.near_y     = near_y_s2;
		side_c.in_box     = !pos_x && !pos_y;
		side_c.use_root   = pos_x && pos_y;
		side_c.single_gap = pos_x ? gpx : gpy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		sqx_s3  <= pbq_pkg::SQ_BITS'(gpx) * pbq_pkg::SQ_BITS'(gpx);
		sqy_s3  <= pbq_pkg::SQ_BITS'(gpy) * pbq_pkg::SQ_BITS'(gpy);
		side_s3 <= side_c;
	end

	// stage 4: sum of squares, saturated to the root operand width
	logic [pbq_pkg::SUM_BITS-1:0] sum;
	logic                         sum_ovf;
	logic                         valid_s4;
	logic [pbq_pkg::RT_BITS-1:0]  rad_s4;
	pbq_pkg::side_t               side_s4;

	assign sum     = pbq_pkg::SUM_BITS'(sqx_s3) + pbq_pkg::SUM_BITS'(sqy_s3);
	assign sum_ovf = (pbq_pkg::SUM_BITS > pbq_pkg::RT_BITS) && sum[pbq_pkg::SUM_BITS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		rad_s4  <= sum_ovf ? '1 : pbq_pkg::RT_BITS'(sum);
		side_s4 <= side_s3;
	end

	assign out_valid = valid_s4;
	assign rad       = rad_s4;
	assign side      = side_s4;

endmodule

`default_nettype wire

// File: rtl/pbq_isqrt.sv
// Pipelined integer square root, one result bit per stage, with sideband
`timescale 1ns / 1ps
`default_nettype none

`include "point_box_query_unit_macros.svh"

module pbq_isqrt (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	input  wire logic [pbq_pkg::RT_BITS-1:0]    rad,
	input  wire pbq_pkg::side_t                 in_side,
	output logic                                out_valid,
	output logic [pbq_pkg::ROOT_BITS-1:0]       root,
	output pbq_pkg::side_t                      out_side
);

	localparam int NR = pbq_pkg::ROOT_BITS;
	localparam int RB = pbq_pkg::RT_BITS;
	localparam int MB = pbq_pkg::REM_BITS;

	// index 0 is the incoming operand, index k the register after stage k
	logic            valid_s [0:NR];
	logic [RB-1:0]   rad_s   [0:NR-1];
	logic [MB-1:0]   rem_s   [0:NR];
	logic [NR-1:0]   root_s  [0:NR];
	pbq_pkg::side_t  side_s  [0:NR];

	assign valid_s[0] = in_valid;
	assign rad_s[0]   = rad;
	assign rem_s[0]   = '0;
	assign root_s[0]  = '0;
	assign side_s[0]  = in_side;

	for (genvar k = 1; k <= NR; k++) begin : g_stage
		logic [MB-1:0] rem_in;
		logic [MB-1:0] trial;
		logic          fits;

		// bring down the next two operand bits, try root*4+1
		assign rem_in = {rem_s[k-1][NR-1:0], rad_s[k-1][RB-1 -: 2]};
		assign trial  = {root_s[k-1], 2'b01};
		assign fits   = (rem_in >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else begin
				valid_s[k] <= valid_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= fits ? (rem_in - trial) : rem_in;
			root_s[k] <= NR'({root_s[k-1], fits});
			side_s[k] <= side_s[k-1];
		end

		if (k < NR) begin : g_shift
			always_ff @(posedge clk) begin
				rad_s[k] <= {rad_s[k-1][RB-3:0], 2'b00};
			end
		end
	end

	assign out_valid = valid_s[NR];
	assign root      = root_s[NR];
	assign out_side  = side_s[NR];

	// a floor root leaves a remainder of at most twice the root
	`PBQ_ASSERT_NEVER(a_rem_bound, clk, arst_n, valid_s[NR] && (rem_s[NR] > {root_s[NR], 1'b0}), "square root remainder out of range")

endmodule

`default_nettype wire
